// ===== hw/rtl/ewp_pkg.sv =====
// ----------------------------------------------------------------------------
// ewp_pkg : shared types and constants of the gaze-weighted PSNR unit
// Holds the sequencer states, request codes, the exp factor constants and
// the request structure passed to the Gaussian weight pipeline.
// ----------------------------------------------------------------------------
package ewp_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_GAZE  = 2'd1,
    MODE_PIXEL = 2'd2,
    MODE_NONE  = 2'd3
  } ewp_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_LOGW_GO,
    ST_LOGW_WAIT,
    ST_LOGE_GO,
    ST_LOGE_WAIT,
    ST_SCALE,
    ST_OUT
  } ewp_state_e;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQR
  } ewp_log_state_e;

  // Request into the Gaussian weight pipeline.
  typedef struct packed {
    logic               valid;
    logic [12:0]        col;
    logic [12:0]        row;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
  } ewp_gauss_req_t;

  localparam int EXP_BITS = 13;

  // exp(-2^i/64) in Q30 for each bit of the table index.
  localparam logic [63:0] EXP_POW_Q30 [EXP_BITS] = '{
    64'd1057095000, 64'd1040706263, 64'd1008687094, 64'd947573834, 64'd836230973,
    64'd651257337, 64'd395007542, 64'd145315153, 64'd19666267, 64'd360200, 64'd121,
    64'd0, 64'd0
  };

  localparam logic [17:0] TEN_OVER_LOG2_10_Q16 = 18'd197283;
  localparam logic [15:0] PEAK_SQ              = 16'd65025;
  localparam logic [47:0] WSUM_MAX             = {48{1'b1}};
  localparam logic [13:0] WIDTH_RESET          = 14'd1920;
  localparam logic [13:0] WIDTH_MAX            = 14'd8192;

endpackage

// ===== hw/rtl/ewp_gauss.sv =====
// ----------------------------------------------------------------------------
// ewp_gauss : pipelined distance and exp table unit
// Takes one gaze point a cycle and returns its Gaussian weight through the difference, square and table read registers.
// ----------------------------------------------------------------------------
module ewp_gauss #(
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ewp_pkg::ewp_gauss_req_t req_i,
  output logic                  valid_o,
  output logic [16:0]           weight_o
);
  import ewp_pkg::*;

  localparam int AW = $clog2(EXP_TABLE_DEPTH);

  typedef logic [16:0] rom_t [EXP_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] p;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      p = 64'd1 << 30;
      for (int b = 0; b < EXP_BITS; b++) begin
        if (((k >> b) & 1) == 1) begin
          p = (p * EXP_POW_Q30[b] + (64'd1 << 29)) >> 30;
        end
      end
      r[k] = 17'((p + (64'd1 << 13)) >> 14);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic               v1_q, v2_q, v3_q;
  logic signed [18:0] dx_q, dy_q;
  logic [35:0]        sqx_q, sqy_q;
  logic [16:0]        rom_q;
  logic               in_range_q;
  logic signed [37:0] sqx_full, sqy_full;
  logic [36:0]        d2;
  logic [21:0]        k;

  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;
  assign d2       = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign k        = d2[36:15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q       <= $signed({2'b00, req_i.col, 4'b0000}) - $signed({{3{req_i.gx[15]}}, req_i.gx});
    dy_q       <= $signed({2'b00, req_i.row, 4'b0000}) - $signed({{3{req_i.gy[15]}}, req_i.gy});
    sqx_q      <= sqx_full[35:0];
    sqy_q      <= sqy_full[35:0];
    rom_q      <= ROM[k[AW-1:0]];
    in_range_q <= (k < 22'(EXP_TABLE_DEPTH));
  end

  assign valid_o  = v3_q;
  assign weight_o = in_range_q ? rom_q : 17'd0;

endmodule

// ===== hw/rtl/ewp_log2.sv =====
// ----------------------------------------------------------------------------
// ewp_log2 : iterative base-two logarithm in Q16
// Normalises one bit a cycle, then finds sixteen fraction bits by squaring.
// ----------------------------------------------------------------------------
module ewp_log2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [21:0] result_o
);
  import ewp_pkg::*;

  ewp_log_state_e state_q, state_d;
  logic [63:0]    x_q;
  logic [5:0]     msb_q;
  logic [31:0]    m_q;
  logic [3:0]     bit_q;
  logic [15:0]    frac_q;
  logic           done_q;
  logic [63:0]    sq;

  assign sq = {32'd0, m_q} * {32'd0, m_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == LG_SQR) && (bit_q == 4'd0);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LG_IDLE: if (start_i) state_d = LG_NORM;
      LG_NORM: if (x_q[63] || msb_q == 6'd0) state_d = LG_SQR;
      LG_SQR:  if (bit_q == 4'd0) state_d = LG_IDLE;
      default: state_d = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      LG_IDLE: begin
        x_q    <= x_i;
        msb_q  <= 6'd63;
        bit_q  <= 4'd15;
        frac_q <= '0;
      end
      LG_NORM: begin
        if (!x_q[63] && msb_q != 6'd0) begin
          x_q   <= {x_q[62:0], 1'b0};
          msb_q <= msb_q - 6'd1;
        end
        m_q <= x_q[63:32];
      end
      LG_SQR: begin
        if (sq[63]) begin
          m_q            <= sq[63:32];
          frac_q[bit_q]  <= 1'b1;
        end else begin
          m_q <= sq[62:31];
        end
        bit_q <= bit_q - 4'd1;
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = {msb_q, frac_q};

endmodule

// ===== hw/rtl/eye_weighted_psnr_unit.sv =====
// ----------------------------------------------------------------------------
// eye_weighted_psnr_unit : gaze-weighted PSNR of one frame
// Sequencer, gaze store and accumulators around the shared weight pipeline
// and the shared logarithm unit.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. Clear and gaze
// requests complete in the cycle they are taken. A pixel request issues one
// gaze point a cycle into the shared distance and exp table pipeline and
// waits for all of its weights to return. The final pixel of a frame then
// runs the shared logarithm unit twice, unless the weight or error sum is
// zero, normalising one bit and squaring once per cycle. The result is shown
// on psnr_db_o, zero_error_o and no_weight_o for exactly one cycle while
// result_valid_o is high; the receiver cannot stall it, so it must capture
// the result in that cycle.
// ----------------------------------------------------------------------------
module eye_weighted_psnr_unit #(
  parameter int GAZE_POINTS     = 15,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  mode_i,
  input  logic signed [15:0]          gaze_x_i,
  input  logic signed [15:0]          gaze_y_i,
  input  logic [7:0]                  orig_pixel_i,
  input  logic [7:0]                  proc_pixel_i,
  input  logic                        last_pixel_i,
  input  logic                        cfg_we_i,
  input  logic [13:0]                 cfg_wdata_i,
  output logic                        result_valid_o,
  output logic [15:0]                 psnr_db_o,
  output logic                        zero_error_o,
  output logic                        no_weight_o
);
  import ewp_pkg::*;

  localparam int CNT_W  = $clog2(GAZE_POINTS + 1);
  localparam int IDX_W  = (GAZE_POINTS > 1) ? $clog2(GAZE_POINTS) : 1;
  localparam int WACC_W = $clog2(65536 * GAZE_POINTS + 1);

  ewp_state_e         state_q, state_d;
  logic [13:0]        frame_width_q;
  logic signed [15:0] gaze_x_q [GAZE_POINTS];
  logic signed [15:0] gaze_y_q [GAZE_POINTS];
  logic [CNT_W-1:0]   gaze_count_q;
  logic [12:0]        col_q, row_q, pcol_q, prow_q;
  logic [CNT_W-1:0]   issue_q, ret_q;
  logic [WACC_W-1:0]  w_acc_q;
  logic [15:0]        err_q;
  logic               last_q;
  logic [WACC_W+15:0] prod_q;
  logic [47:0]        weight_sum_q;
  logic [63:0]        err_sum_q;
  logic [21:0]        lw_q;
  logic [39:0]        scaled_q;
  logic               pos_q, nw_q, ze_q;
  logic               res_valid_q, res_ze_q, res_nw_q;
  logic [15:0]        res_psnr_q;

  logic               accept;
  logic [13:0]        width_eff;
  logic signed [17:0] diff;
  logic [17:0]        diff_sq;
  logic [48:0]        wsum_next;
  logic [64:0]        esum_next;
  ewp_gauss_req_t     greq;
  logic               g_valid;
  logic [16:0]        g_weight;
  logic               log_start, log_done;
  logic [63:0]        log_x;
  logic [21:0]        log_res;
  logic signed [22:0] ldiff;
  logic [39:0]        scaled_full;
  logic [40:0]        rounded;
  logic [16:0]        psnr_v;

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;

  assign width_eff = (frame_width_q == 14'd0) ? 14'd1 :
                     (frame_width_q > WIDTH_MAX) ? WIDTH_MAX : frame_width_q;
  assign diff      = $signed({10'd0, orig_pixel_i}) - $signed({10'd0, proc_pixel_i});
  assign diff_sq   = $unsigned(diff * diff);

  assign wsum_next = {1'b0, weight_sum_q} + 49'(prod_q[0] & 1'b0) + 49'(w_acc_q);
  assign esum_next = {1'b0, err_sum_q} + 65'(prod_q);

  // The weight pipeline is fed straight from the gaze store.
  always_comb begin
    greq.valid = (state_q == ST_ISSUE);
    greq.col   = pcol_q;
    greq.row   = prow_q;
    greq.gx    = gaze_x_q[issue_q[IDX_W-1:0]];
    greq.gy    = gaze_y_q[issue_q[IDX_W-1:0]];
  end

  ewp_gauss #(
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_gauss (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (greq),
    .valid_o (g_valid),
    .weight_o(g_weight)
  );

  // The peak-scaled weight sum is logged first, then the error sum.
  assign log_start = (state_q == ST_LOGW_GO) || (state_q == ST_LOGE_GO);
  assign log_x     = (state_q == ST_LOGW_GO) ? ({16'd0, weight_sum_q} * {48'd0, PEAK_SQ})
                                             : err_sum_q;

  ewp_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .result_o(log_res)
  );

  assign ldiff       = $signed({1'b0, lw_q}) - $signed({1'b0, log_res});
  assign scaled_full = {18'd0, ldiff[21:0]} * {22'd0, TEN_OVER_LOG2_10_Q16};
  assign rounded     = {1'b0, scaled_q} + 41'(1 << 23);
  assign psnr_v      = rounded[40:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && mode_i == MODE_PIXEL) begin
          state_d = (gaze_count_q != '0) ? ST_ISSUE : ST_MUL;
        end
      end
      ST_ISSUE: begin
        if (issue_q == gaze_count_q - CNT_W'(1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (g_valid && (ret_q + CNT_W'(1)) == gaze_count_q) state_d = ST_MUL;
      end
      ST_MUL:       state_d = ST_ACC;
      ST_ACC:       state_d = last_q ? ST_CHECK : ST_IDLE;
      ST_CHECK: begin
        if (weight_sum_q == '0 || err_sum_q == '0) state_d = ST_OUT;
        else state_d = ST_LOGW_GO;
      end
      ST_LOGW_GO:   state_d = ST_LOGW_WAIT;
      ST_LOGW_WAIT: if (log_done) state_d = ST_LOGE_GO;
      ST_LOGE_GO:   state_d = ST_LOGE_WAIT;
      ST_LOGE_WAIT: if (log_done) state_d = ST_SCALE;
      ST_SCALE:     state_d = ST_OUT;
      ST_OUT:       state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Control registers: configuration, counts, pixel position, sums and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= WIDTH_RESET;
      gaze_count_q  <= '0;
      col_q         <= '0;
      row_q         <= '0;
      weight_sum_q  <= '0;
      err_sum_q     <= '0;
      issue_q       <= '0;
      ret_q         <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= (state_q == ST_OUT);
      if (cfg_we_i) frame_width_q <= cfg_wdata_i;
      if (accept) begin
        unique case (mode_i)
          MODE_CLEAR: begin
            gaze_count_q <= '0;
            col_q        <= '0;
            row_q        <= '0;
            weight_sum_q <= '0;
            err_sum_q    <= '0;
          end
          MODE_GAZE: begin
            if (gaze_count_q < CNT_W'(GAZE_POINTS)) gaze_count_q <= gaze_count_q + CNT_W'(1);
          end
          MODE_PIXEL: begin
            issue_q <= '0;
            ret_q   <= '0;
            if (last_pixel_i) begin
              col_q <= '0;
              row_q <= '0;
            end else if ({1'b0, col_q} + 14'd1 >= width_eff) begin
              col_q <= '0;
              row_q <= row_q + 13'd1;
            end else begin
              col_q <= col_q + 13'd1;
            end
          end
          default: ;
        endcase
      end
      if (state_q == ST_ISSUE) issue_q <= issue_q + CNT_W'(1);
      if (g_valid) ret_q <= ret_q + CNT_W'(1);
      if (state_q == ST_ACC) begin
        weight_sum_q <= wsum_next[48] ? WSUM_MAX : wsum_next[47:0];
        err_sum_q    <= esum_next[64] ? {64{1'b1}} : esum_next[63:0];
      end
      if (state_q == ST_OUT) begin
        weight_sum_q <= '0;
        err_sum_q    <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept && mode_i == MODE_GAZE && gaze_count_q < CNT_W'(GAZE_POINTS)) begin
      gaze_x_q[gaze_count_q[IDX_W-1:0]] <= gaze_x_i;
      gaze_y_q[gaze_count_q[IDX_W-1:0]] <= gaze_y_i;
    end
    if (accept && mode_i == MODE_PIXEL) begin
      pcol_q  <= col_q;
      prow_q  <= row_q;
      err_q   <= diff_sq[15:0];
      last_q  <= last_pixel_i;
      w_acc_q <= '0;
    end else if (g_valid) begin
      w_acc_q <= w_acc_q + WACC_W'(g_weight);
    end
    if (state_q == ST_MUL)   prod_q <= w_acc_q * err_q;
    if (state_q == ST_CHECK) begin
      nw_q  <= (weight_sum_q == '0);
      ze_q  <= (err_sum_q == '0);
      pos_q <= 1'b0;
    end
    if (state_q == ST_LOGW_WAIT && log_done) lw_q <= log_res;
    if (state_q == ST_LOGE_WAIT && log_done) begin
      pos_q    <= (ldiff > 23'sd0);
      scaled_q <= scaled_full;
    end
    if (state_q == ST_OUT) begin
      res_nw_q <= nw_q;
      res_ze_q <= ze_q;
      if (nw_q)                      res_psnr_q <= 16'd0;
      else if (ze_q)                 res_psnr_q <= 16'hFFFF;
      else if (!pos_q)               res_psnr_q <= 16'd0;
      else if (psnr_v > 17'd65535)   res_psnr_q <= 16'hFFFF;
      else                           res_psnr_q <= psnr_v[15:0];
    end
  end

  assign result_valid_o = res_valid_q;
  assign psnr_db_o      = res_psnr_q;
  assign zero_error_o   = res_ze_q;
  assign no_weight_o    = res_nw_q;

  // The result strobe lasts one cycle only.
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe held longer than one cycle");

  // Issue never runs past the loaded gaze points.
  a_issue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> (issue_q < gaze_count_q))
    else $error("gaze issue beyond loaded points");

  // Returned weights never outnumber issued gaze points.
  a_ret_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE || state_q == ST_DRAIN) |-> (ret_q <= issue_q))
    else $error("weight returned without a request");

  // A result only follows the output state.
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == ST_OUT))
    else $error("result strobe without output state");

endmodule
